[rtl/core/mlm_pkg.sv]
// Shared types and constants for the mask leak monitor core.
// Depends on nothing; mlm_windows and the core top import it.
`default_nettype none

package mlm_pkg;

    // Short window holds 2**WIN_LOG2 samples, long window twice as many.
    localparam int WIN_LOG2   = 5;
    localparam int WINDOW_LEN = 1 << WIN_LOG2;

    localparam int SAMPLE_W = 16;
    localparam int SIDX_W   = WIN_LOG2;
    localparam int LIDX_W   = WIN_LOG2 + 1;
    localparam int SSUM_W   = SAMPLE_W + WIN_LOG2;
    localparam int LSUM_W   = SAMPLE_W + WIN_LOG2 + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [15:0] LEAK_HIGH_RST    = 16'sd5000;
    localparam logic signed [15:0] LEAK_LOW_RST     = 16'sd3000;
    localparam logic [15:0]        TARGET_PRESS_RST = 16'd1000;
    localparam logic [15:0]        START_PRESS_RST  = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEAK_HIGH    = 2'd0,
        CFG_LEAK_LOW     = 2'd1,
        CFG_TARGET_PRESS = 2'd2,
        CFG_START_PRESS  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STAGE_STOP  = 2'd0,
        STAGE_START = 2'd1,
        STAGE_RUN   = 2'd2
    } stage_t;

    // Sequencer to window unit
    typedef struct packed {
        logic clear;
        logic run;
    } win_ctl_t;

    // Window unit to sequencer
    typedef struct packed {
        logic               priming;
        logic signed [15:0] leak_cur;
        logic signed [15:0] mean_next;
        logic signed [15:0] leak_next;
    } win_stat_t;

endpackage

`default_nettype wire

[rtl/core/mlm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for both sample rings of the core.
`default_nettype none

module mlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/core/mlm_windows.sv]
// Short and long sliding windows: rings, running sums, indices and means.
// Depends on mlm_pkg and mlm_ram.
`default_nettype none

module mlm_windows (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mlm_pkg::win_ctl_t           ctl,
    input  wire logic signed [15:0]          sample,
    output mlm_pkg::win_stat_t               stat
);
    import mlm_pkg::*;

    logic [SIDX_W-1:0]        s_idx_reg, s_idx_next;
    logic [LIDX_W-1:0]        l_idx_reg, l_idx_next;
    logic signed [SSUM_W-1:0] s_sum_reg, s_sum_next, s_sum_slide, s_bias;
    logic signed [LSUM_W-1:0] l_sum_reg, l_sum_next, l_bias;
    logic                     priming_reg, priming_next;
    logic                     full_reg, full_next;
    logic signed [15:0]       mean_reg, mean_next;
    logic signed [15:0]       leak_reg, leak_next;
    logic [SAMPLE_W-1:0]      s_old_raw, l_old_raw;
    logic signed [SSUM_W-1:0] x_s, s_old;
    logic signed [LSUM_W-1:0] x_l, l_old;
    logic signed [SSUM_W-1:0] s_quot;
    logic signed [LSUM_W-1:0] l_quot;

    // Read address runs one item ahead: the ring entry at the index left by
    // this item is in rd_data when the next item arrives.
    mlm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_LEN)) u_short_ring (
        .clk     (clk),
        .wr_en   (ctl.run),
        .wr_addr (s_idx_reg),
        .wr_data (sample),
        .rd_addr (s_idx_next),
        .rd_data (s_old_raw)
    );

    mlm_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 * WINDOW_LEN)) u_long_ring (
        .clk     (clk),
        .wr_en   (ctl.run),
        .wr_addr (l_idx_reg),
        .wr_data (sample),
        .rd_addr (l_idx_next),
        .rd_data (l_old_raw)
    );

    assign x_s   = {{(SSUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    assign x_l   = {{(LSUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    assign s_old = {{(SSUM_W-SAMPLE_W){s_old_raw[SAMPLE_W-1]}}, s_old_raw};
    assign l_old = {{(LSUM_W-SAMPLE_W){l_old_raw[SAMPLE_W-1]}}, l_old_raw};

    // Sum after the slide; the result always fits, so modular math is exact.
    assign s_sum_slide = s_sum_reg - s_old + x_s;

    // Truncating division by a power of two: bias negative sums first.
    assign s_bias = s_sum_slide
        + (s_sum_slide[SSUM_W-1] ? SSUM_W'(WINDOW_LEN - 1) : SSUM_W'(0));
    assign s_quot = s_bias >>> WIN_LOG2;
    assign l_bias = l_sum_reg
        + (l_sum_reg[LSUM_W-1] ? LSUM_W'(2 * WINDOW_LEN - 1) : LSUM_W'(0));
    assign l_quot = l_bias >>> (WIN_LOG2 + 1);

    always_comb
    begin
        s_idx_next   = s_idx_reg;
        l_idx_next   = l_idx_reg;
        s_sum_next   = s_sum_reg;
        l_sum_next   = l_sum_reg;
        priming_next = priming_reg;
        full_next    = full_reg;
        mean_next    = mean_reg;
        leak_next    = leak_reg;
        if (ctl.clear)
        begin
            s_idx_next   = '0;
            l_idx_next   = '0;
            s_sum_next   = '0;
            l_sum_next   = '0;
            priming_next = 1'b1;
            full_next    = 1'b0;
            mean_next    = '0;
            leak_next    = '0;
        end
        else if (ctl.run)
        begin
            s_idx_next = s_idx_reg + 1'b1;
            l_idx_next = l_idx_reg + 1'b1;
            if (priming_reg)
            begin
                s_sum_next = s_sum_reg + x_s;
                if (s_idx_reg == {SIDX_W{1'b1}})
                begin
                    priming_next = 1'b0;
                end
            end
            else
            begin
                s_sum_next = s_sum_slide;
                mean_next  = s_quot[15:0];
            end
            if (!full_reg)
            begin
                l_sum_next = l_sum_reg + x_l;
                if (l_idx_reg == {LIDX_W{1'b1}})
                begin
                    full_next = 1'b1;
                end
            end
            else
            begin
                leak_next  = l_quot[15:0];
                l_sum_next = l_sum_reg - l_old + x_l;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_idx_reg   <= '0;
            l_idx_reg   <= '0;
            s_sum_reg   <= '0;
            l_sum_reg   <= '0;
            priming_reg <= 1'b1;
            full_reg    <= 1'b0;
            mean_reg    <= '0;
            leak_reg    <= '0;
        end
        else
        begin
            s_idx_reg   <= s_idx_next;
            l_idx_reg   <= l_idx_next;
            s_sum_reg   <= s_sum_next;
            l_sum_reg   <= l_sum_next;
            priming_reg <= priming_next;
            full_reg    <= full_next;
            mean_reg    <= mean_next;
            leak_reg    <= leak_next;
        end
    end

    assign stat.priming   = priming_reg;
    assign stat.leak_cur  = leak_reg;
    assign stat.mean_next = mean_next;
    assign stat.leak_next = leak_next;

endmodule

`default_nettype wire

[rtl/core/mask_leak_monitor_core.sv]
// Mask leak monitor: test sequencer, setpoint ramp, leak hysteresis flag.
// Items pass the input register, then the result register, which holds while
// out_ready is low. Throughput: one item per cycle when not stalled, set by the
// single ring read and write per sample in each window. Reset (rst_n, async,
// low): stage stopped, sums and means zero, priming set, registers at defaults.
// Depends on mlm_pkg and mlm_windows (which uses mlm_ram).
`default_nettype none

module mask_leak_monitor_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input item channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [15:0]               flow_sample,
    input  wire logic                             start_request,
    input  wire logic                             pid_on,
    // result item channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [1:0]                            test_stage,
    output logic                                  test_active,
    output logic [15:0]                           pressure_setpoint,
    output logic signed [15:0]                    flow_avg,
    output logic signed [15:0]                    leak_mean,
    output logic                                  adjust_mask,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mlm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mlm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mlm_pkg::*;

    // Configuration registers
    logic signed [15:0] leak_high_reg, leak_low_reg;
    logic [15:0]        target_reg, start_press_reg;

    // Input register
    logic               s1_valid_reg;
    logic signed [15:0] s1_sample_reg;
    logic               s1_req_reg, s1_pid_reg;

    // Sequencer state
    stage_t             stage_reg, stage_next, stage_mid;
    logic [15:0]        setpoint_reg, setpoint_next;
    logic               flag_reg, flag_next;

    // Result register
    logic               out_valid_reg;
    stage_t             out_stage_reg;
    logic               out_active_reg;
    logic [15:0]        out_setpoint_reg;
    logic signed [15:0] out_mean_reg, out_leak_reg;
    logic               out_flag_reg;

    logic               fire;
    win_ctl_t           win_ctl;
    win_stat_t          win_stat;

    // Process the held item when the result register is free or draining.
    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || fire;

    // Configuration is always taken; unknown indices simply fall through.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_high_reg   <= LEAK_HIGH_RST;
            leak_low_reg    <= LEAK_LOW_RST;
            target_reg      <= TARGET_PRESS_RST;
            start_press_reg <= START_PRESS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_LEAK_HIGH:    leak_high_reg   <= cfg_data;
                CFG_LEAK_LOW:     leak_low_reg    <= cfg_data;
                CFG_TARGET_PRESS: target_reg      <= cfg_data;
                CFG_START_PRESS:  start_press_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input register: hold the item until the sequencer consumes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_sample_reg <= flow_sample;
            s1_req_reg    <= start_request;
            s1_pid_reg    <= pid_on;
        end
    end

    // Sequencer: stage change from the request bit first, then the action
    // of the stage it lands in.
    always_comb
    begin
        stage_mid = stage_reg;
        priority if (stage_reg == STAGE_STOP && s1_req_reg)
        begin
            stage_mid = STAGE_START;
        end
        else if (stage_reg != STAGE_STOP && !s1_req_reg)
        begin
            stage_mid = STAGE_STOP;
        end
        else
        begin
            stage_mid = stage_reg;
        end

        stage_next    = stage_reg;
        setpoint_next = setpoint_reg;
        flag_next     = flag_reg;
        win_ctl.clear = 1'b0;
        win_ctl.run   = 1'b0;

        if (fire)
        begin
            stage_next = stage_mid;
            unique case (stage_mid)
                STAGE_STOP:
                begin
                    win_ctl.clear = 1'b1;
                    setpoint_next = '0;
                    flag_next     = 1'b0;
                end
                STAGE_START:
                begin
                    setpoint_next = start_press_reg;
                    if (s1_pid_reg)
                    begin
                        stage_next = STAGE_RUN;
                    end
                end
                STAGE_RUN:
                begin
                    if (!win_stat.priming)
                    begin
                        // Ramp by one, or snap to the ceiling.
                        if (setpoint_reg >= target_reg)
                        begin
                            setpoint_next = target_reg;
                        end
                        else
                        begin
                            setpoint_next = setpoint_reg + 16'd1;
                        end
                        // Hysteresis on the leak mean left by the last item;
                        // the set test wins even with crossed thresholds.
                        priority if (win_stat.leak_cur > leak_high_reg && !flag_reg)
                        begin
                            flag_next = 1'b1;
                        end
                        else if (win_stat.leak_cur < leak_low_reg && flag_reg)
                        begin
                            flag_next = 1'b0;
                        end
                        else
                        begin
                            flag_next = flag_reg;
                        end
                    end
                end
                default:
                begin
                    stage_next    = STAGE_STOP;
                    win_ctl.clear = 1'b1;
                    setpoint_next = '0;
                    flag_next     = 1'b0;
                end
            endcase
            win_ctl.run = (stage_next == STAGE_RUN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg    <= STAGE_STOP;
            setpoint_reg <= '0;
            flag_reg     <= 1'b0;
        end
        else
        begin
            stage_reg    <= stage_next;
            setpoint_reg <= setpoint_next;
            flag_reg     <= flag_next;
        end
    end

    mlm_windows u_windows (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (win_ctl),
        .sample (s1_sample_reg),
        .stat   (win_stat)
    );

    // Result register: advance on fire, drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_stage_reg    <= stage_next;
            out_active_reg   <= (stage_next != STAGE_STOP);
            out_setpoint_reg <= setpoint_next;
            out_mean_reg     <= win_stat.mean_next;
            out_leak_reg     <= win_stat.leak_next;
            out_flag_reg     <= flag_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign test_stage        = out_stage_reg;
    assign test_active       = out_active_reg;
    assign pressure_setpoint = out_setpoint_reg;
    assign flow_avg          = out_mean_reg;
    assign leak_mean         = out_leak_reg;
    assign adjust_mask       = out_flag_reg;

    // A stopped test leaves no setpoint and no flag behind.
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == STAGE_STOP |-> setpoint_reg == 16'd0 && !flag_reg)
        else $error("setpoint or flag left set while stopped");

    // The stage only moves when an item is processed.
    a_stage_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(stage_reg))
        else $error("stage changed without an item");

    // A delivered result reports activity consistent with its stage.
    a_active_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_active_reg == (out_stage_reg != STAGE_STOP))
        else $error("test_active disagrees with test_stage");

    // An item held in the input register is processed once the result
    // register has room.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held item not processed into free result register");

endmodule

`default_nettype wire

[test/mlm_checker.sv]
`timescale 1ns / 1ps
// Checker for mask_leak_monitor_core: follows the item, result and register channels,
// predicts each result item and compares it field by field. Depends on mlm_pkg.

module mlm_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic signed [15:0]             flow_sample,
    input  wire logic                           start_request,
    input  wire logic                           pid_on,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [1:0]                     test_stage,
    input  wire logic                           test_active,
    input  wire logic [15:0]                    pressure_setpoint,
    input  wire logic signed [15:0]             flow_avg,
    input  wire logic signed [15:0]             leak_mean,
    input  wire logic                           adjust_mask,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [mlm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mlm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  checked,
    output int                                  flag_sets
);
    import mlm_pkg::*;

    localparam int LONG_LEN     = 2 * WINDOW_LEN;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        stage_t             stage;
        logic               active;
        logic [15:0]        setpoint;
        logic signed [15:0] mean;
        logic signed [15:0] leak;
        logic               adjust;
    } monitor_reading_t;

    // register copies
    logic signed [15:0] leak_high;
    logic signed [15:0] leak_low;
    logic [15:0]        target_press;
    logic [15:0]        start_press;

    // predicted block state
    stage_t             stage;
    logic               priming;
    logic               long_full;
    logic               adjust;
    logic signed [15:0] short_ring [WINDOW_LEN];
    logic signed [15:0] long_ring [LONG_LEN];
    int                 short_idx;
    int                 long_idx;
    longint             short_sum;
    longint             long_sum;
    logic [15:0]        setpoint;
    logic signed [15:0] mean_reg;
    logic signed [15:0] leak_reg;

    monitor_reading_t   expected_readings [$];

    task automatic clear_test();
        priming   = 1'b1;
        short_idx = 0;
        long_idx  = 0;
        long_full = 1'b0;
        short_sum = 0;
        long_sum  = 0;
        setpoint  = '0;
        mean_reg  = '0;
        leak_reg  = '0;
        adjust    = 1'b0;
    endtask

    task automatic predict_tick(input logic signed [15:0] flow, input logic req,
                                input logic pid, output monitor_reading_t res);
        // sequencer transition first, then the action of the stage it lands in
        if (stage == STAGE_STOP && req)
            stage = STAGE_START;
        else if (stage != STAGE_STOP && !req)
            stage = STAGE_STOP;

        case (stage)
            STAGE_STOP:
                clear_test();
            STAGE_START:
            begin
                setpoint = start_press;
                if (pid)
                    stage = STAGE_RUN;
            end
            STAGE_RUN:
                if (!priming)
                begin
                    if (setpoint >= target_press)
                        setpoint = target_press;
                    else
                        setpoint = setpoint + 16'd1;
                    // set test wins, even with inverted thresholds
                    if (leak_reg > leak_high && !adjust)
                    begin
                        adjust = 1'b1;
                        flag_sets++;
                    end
                    else if (leak_reg < leak_low && adjust)
                        adjust = 1'b0;
                end
            default: ;
        endcase

        if (stage == STAGE_RUN)
        begin
            if (priming)
            begin
                short_ring[short_idx] = flow;
                short_sum += flow;
                short_idx++;
                if (short_idx >= WINDOW_LEN)
                begin
                    short_idx = 0;
                    priming   = 1'b0;
                end
            end
            else
            begin
                short_sum = short_sum - short_ring[short_idx] + flow;
                mean_reg  = 16'(short_sum / WINDOW_LEN);
                short_ring[short_idx] = flow;
                short_idx = (short_idx + 1) % WINDOW_LEN;
            end

            if (!long_full)
            begin
                long_ring[long_idx] = flow;
                long_sum += flow;
                long_idx++;
                if (long_idx >= LONG_LEN)
                begin
                    long_idx  = 0;
                    long_full = 1'b1;
                end
            end
            else
            begin
                // leak mean comes from the sum before this sample enters
                leak_reg = 16'(long_sum / LONG_LEN);
                long_sum = long_sum - long_ring[long_idx] + flow;
                long_ring[long_idx] = flow;
                long_idx = (long_idx + 1) % LONG_LEN;
            end
        end

        res.stage    = stage;
        res.active   = (stage != STAGE_STOP);
        res.setpoint = (stage == STAGE_STOP) ? 16'd0 : setpoint;
        res.mean     = mean_reg;
        res.leak     = leak_reg;
        res.adjust   = adjust;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            if (mismatches < REPORT_LIMIT)
                $display("%0t: %s mismatch on result %0d: expected %h, got %h",
                         $time, name, checked, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        monitor_reading_t want;
        monitor_reading_t next_reading;
        if (!rst_n)
        begin
            leak_high    = LEAK_HIGH_RST;
            leak_low     = LEAK_LOW_RST;
            target_press = TARGET_PRESS_RST;
            start_press  = START_PRESS_RST;
            stage        = STAGE_STOP;
            for (int i = 0; i < WINDOW_LEN; i++)
                short_ring[i] = '0;
            for (int i = 0; i < LONG_LEN; i++)
                long_ring[i] = '0;
            clear_test();
            expected_readings.delete();
            mismatches = 0;
            pending    = 0;
            checked    = 0;
            flag_sets  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: result item with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("test_stage", 16'(want.stage), 16'(test_stage));
                    check_field("test_active", 16'(want.active), 16'(test_active));
                    check_field("pressure_setpoint", want.setpoint, pressure_setpoint);
                    check_field("flow_avg", want.mean, flow_avg);
                    check_field("leak_mean", want.leak, leak_mean);
                    check_field("adjust_mask", 16'(want.adjust), 16'(adjust_mask));
                    checked++;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_LEAK_HIGH:    leak_high    = cfg_data;
                    CFG_LEAK_LOW:     leak_low     = cfg_data;
                    CFG_TARGET_PRESS: target_press = cfg_data;
                    CFG_START_PRESS:  start_press  = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                predict_tick(flow_sample, start_request, pid_on, next_reading);
                expected_readings.push_back(next_reading);
            end

            pending = expected_readings.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Top of the mask leak monitor testbench: clock, reset, item and register stimulus,
// result-side flow control and the verdict. Depends on mlm_pkg, the core and mlm_checker.

module tb_top;
    import mlm_pkg::*;

    localparam int DIRECTED_ITEMS = 19;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int STALL_CYCLES   = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 1000000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [15:0]   flow_sample;
    logic                 start_request;
    logic                 pid_on;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           test_stage;
    logic                 test_active;
    logic [15:0]          pressure_setpoint;
    logic signed [15:0]   flow_avg;
    logic signed [15:0]   leak_mean;
    logic                 adjust_mask;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int checked;
    int flag_sets;

    // Shared between the item sender and the result sink
    logic stall_out_req;   // ask the sink for one long hold-off
    logic no_idle;         // both sides run without gaps
    int   items_sent;
    int   settings_applied;
    int   cur_high;        // thresholds as last written, to aim the flow levels
    int   cur_low;
    int   cycle_count;

    mask_leak_monitor_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .flow_sample       (flow_sample),
        .start_request     (start_request),
        .pid_on            (pid_on),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .test_stage        (test_stage),
        .test_active       (test_active),
        .pressure_setpoint (pressure_setpoint),
        .flow_avg          (flow_avg),
        .leak_mean         (leak_mean),
        .adjust_mask       (adjust_mask),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    mlm_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .flow_sample       (flow_sample),
        .start_request     (start_request),
        .pid_on            (pid_on),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .test_stage        (test_stage),
        .test_active       (test_active),
        .pressure_setpoint (pressure_setpoint),
        .flow_avg          (flow_avg),
        .leak_mean         (leak_mean),
        .adjust_mask       (adjust_mask),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .pending           (pending),
        .checked           (checked),
        .flag_sets         (flag_sets)
    );

    always #6 clk = ~clk;

    // Hard stop in case the block hangs a handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results still due", cycle_count,
                     pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Gap length: mostly short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(3, 1);
        else if (r < 96)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // Flow level around a center, clamped to the sensor range
    function automatic logic signed [15:0] flow_near(int center, int spread);
        int v;
        v = center - spread + int'($urandom_range(2 * spread));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // Threshold-ish value: usually near zero so flow can cross it, sometimes anywhere
    function automatic int rand_threshold();
        if ($urandom_range(3) == 0)
            return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(16000)) - 8000;
    endfunction

    function automatic int rand_pressure();
        if ($urandom_range(3) == 0)
            return $urandom_range(65535);
        return $urandom_range(2000);
    endfunction

    // Offer one item; open with a random gap unless the run is gap-free
    task automatic send_item(input logic signed [15:0] flow, input logic req,
                             input logic pid);
        int gap;
        gap = (no_idle || $urandom_range(99) < 55) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        flow_sample   <= flow;
        start_request <= req;
        pid_on        <= pid;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all four registers while the block is idle; the test stage itself carries on
    task automatic apply_settings(input int hi, input int lo, input int tgt, input int st);
        drain_results();
        write_reg(CFG_LEAK_HIGH, 16'(hi));
        write_reg(CFG_LEAK_LOW, 16'(lo));
        write_reg(CFG_TARGET_PRESS, 16'(tgt));
        write_reg(CFG_START_PRESS, 16'(st));
        cur_high = hi;
        cur_low  = lo;
        settings_applied++;
    endtask

    // Pick a flow level that lands above the set threshold, below the clear threshold,
    // between them, or at a rail so the sums hit their extremes
    function automatic int pick_level();
        int r;
        int top;
        int bottom;
        r      = $urandom_range(19);
        top    = (cur_high > cur_low) ? cur_high : cur_low;
        bottom = (cur_high > cur_low) ? cur_low : cur_high;
        if (r == 0)
            return 32767;
        else if (r == 1)
            return -32768;
        else if (r < 8)
            return top + int'($urandom_range(3000, 200));
        else if (r < 15)
            return bottom - int'($urandom_range(3000, 200));
        else
            return (top + bottom) / 2;
    endfunction

    // One mask test: stop, wait in start for the regulator, then run long enough to prime
    // and fill both windows. With fresh low the running test simply goes on.
    task automatic run_mask_test(input logic fresh, input int run_len);
        int level;
        int spread;
        int seg_left;
        seg_left = 0;
        level    = 0;
        spread   = 0;
        if (fresh)
        begin
            repeat ($urandom_range(2, 1)) send_item(16'($urandom), 1'b0, rand_bit());
            repeat ($urandom_range(3)) send_item(16'($urandom), 1'b1, 1'b0);
            send_item(16'($urandom), 1'b1, 1'b1);
        end
        for (int k = 0; k < run_len; k++)
        begin
            if (seg_left == 0)
            begin
                level    = pick_level();
                spread   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1500);
                seg_left = $urandom_range(120, 30);
            end
            seg_left--;
            // now and then drop the request mid-run: back to stop, then restart
            if ($urandom_range(199) == 0)
                send_item(flow_near(level, spread), 1'b0, rand_bit());
            else
                send_item(flow_near(level, spread), 1'b1, rand_bit());
        end
    endtask

    // Result sink: random ready with short and long gaps, plus the one long hold-off
    initial
    begin : result_sink
        int idle_left;
        idle_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_out_req)
            begin
                out_ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge clk);
                stall_out_req = 1'b0;
            end
            else if (idle_left > 0)
            begin
                out_ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!no_idle && $urandom_range(3) == 0)
                    idle_left = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        logic saved_no_idle;

        clk              = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        flow_sample      = '0;
        start_request    = 1'b0;
        pid_on           = 1'b0;
        out_ready        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_LEAK_HIGH;
        cfg_data         = '0;
        stall_out_req    = 1'b0;
        no_idle          = 1'b0;
        items_sent       = 0;
        settings_applied = 0;
        cycle_count      = 0;
        cur_high         = LEAK_HIGH_RST;
        cur_low          = LEAK_LOW_RST;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: rails of the flow field, every stage change, start to run in one tick
        send_item(16'sh7FFF, 1'b0, 1'b0);   // stopped, top rail
        send_item(16'sh8000, 1'b0, 1'b1);   // stopped, bottom rail, regulator on
        send_item(16'sh0000, 1'b1, 1'b0);   // stop -> start
        send_item(16'sh0001, 1'b1, 1'b0);   // hold in start
        send_item(16'shFFFF, 1'b0, 1'b0);   // start -> stop
        send_item(16'sh0064, 1'b1, 1'b1);   // stop -> start -> run in one tick
        send_item(16'sh7FFF, 1'b1, 1'b0);
        send_item(16'sh8000, 1'b1, 1'b1);
        send_item(16'sh7FFF, 1'b1, 1'b0);
        send_item(16'sh8000, 1'b1, 1'b1);
        send_item(16'sh0000, 1'b1, 1'b0);
        send_item(16'shFFFF, 1'b1, 1'b1);
        send_item(16'sh0001, 1'b1, 1'b0);
        send_item(16'sh3039, 1'b1, 1'b1);
        send_item(16'sh0005, 1'b0, 1'b1);   // run -> stop
        send_item(16'sh0007, 1'b1, 1'b0);   // start, regulator off
        send_item(16'sh0008, 1'b1, 1'b1);   // enter run
        send_item(16'sh0009, 1'b1, 1'b0);   // run ignores pid_on
        send_item(16'shFFF7, 1'b0, 1'b0);   // stop

        // Random phases, each under its own register setting
        phase = 0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            case (phase)
                0: apply_settings(5000, 3000, 1000, 200);
                1: apply_settings(32767, -32768, 65535, 65535);
                // minimum set level, maximum clear level: the flag flips every tick
                2: apply_settings(-32768, 32767, 0, 0);
                // inverted thresholds, start pressure above the ceiling
                3: apply_settings(1000, 4000, 300, 500);
                // ramp runs into the top of the range
                4: apply_settings(32767, 32767, 65535, 65530);
                // lowered ceiling during a running test pulls the setpoint down at once
                5: apply_settings(2000, -2000, 400, 350);
                default: apply_settings(rand_threshold(), rand_threshold(),
                                        rand_pressure(), rand_pressure());
            endcase

            no_idle = (phase % 4 == 3);

            if (phase % 2 == 1)
            begin
                // keep the running test going across the register change
                run_mask_test(1'b0, $urandom_range(160, 60));
            end
            else
            begin
                repeat ($urandom_range(25, 8))
                    send_item(16'($urandom), rand_bit(), rand_bit());
                run_mask_test(1'b1, $urandom_range(200, 90));
            end

            if (phase == 2 || phase == 7)
            begin
                // Hold the result side off while items keep coming: fill the block
                saved_no_idle = no_idle;
                stall_out_req = 1'b1;
                no_idle       = 1'b1;
                repeat (40) send_item(flow_near(cur_high, 4000), 1'b1, rand_bit());
                no_idle = saved_no_idle;
            end

            if ($urandom_range(1) == 0)
                run_mask_test(1'b1, $urandom_range(150, 90));

            no_idle = 1'b0;
            phase++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d items and %0d checked results under %0d register settings,",
                 items_sent, checked, settings_applied);
        $display("with the leak flag predicted to set %0d times.", flag_sets);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
